[sv/lhp_pkg.sv]
// Shared constants, types and helper functions for the latency histogram block.
// No dependencies; every other file imports this package.
`default_nettype none

package lhp_pkg;

  localparam int MAX_BOUNDS   = 8;
  localparam int BUCKET_SLOTS = MAX_BOUNDS + 1;
  localparam int PAIRS        = MAX_BOUNDS / 2;
  localparam int BOUND_W      = 32;
  localparam int DATA_W       = 64;
  localparam int PCT_W        = 14;
  localparam int FULL_SCALE   = 10000;
  localparam int PROD_W       = DATA_W + PCT_W;
  localparam int STEP_W       = $clog2(PCT_W);
  localparam int SLOT_W       = $clog2(BUCKET_SLOTS);
  localparam int BIDX_W       = $clog2(MAX_BOUNDS);
  localparam int ANS_W        = BOUND_W + 1;
  localparam int NUSE_W       = 4;
  localparam int CFG_DW       = 64;
  localparam int CFG_AW       = 6;
  localparam int REG_LSB      = 3;

  // Full scale times two to the 64, dropped from the scaled total when the
  // 64-bit running total of a walk wraps.
  localparam logic [PROD_W:0] WRAP_SCALED = (PROD_W+1)'(FULL_SCALE) << DATA_W;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_QUERY  = 1'b1
  } req_t;

  typedef enum logic [CFG_AW-REG_LSB-1:0] {
    REG_BOUNDS_IN_USE = 3'd0,
    REG_PAIR_0        = 3'd1,
    REG_PAIR_1        = 3'd2,
    REG_PAIR_2        = 3'd3,
    REG_PAIR_3        = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_MUL,
    ST_TGT,
    ST_WALK,
    ST_DONE
  } lhp_state_t;

  typedef struct packed {
    logic [NUSE_W-1:0]                    n_raw;
    logic [MAX_BOUNDS-1:0][BOUND_W-1:0]   bound;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic rec_commit;
    logic mul_step;
    logic tgt_load;
    logic walk_step;
    logic qry_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic mul_last;
    logic walk_end;
    logic out_free;
  } stat_t;

  // Number of bounds in use, with zero read as one and large values clipped.
  function automatic logic [SLOT_W-1:0] active_bounds(input logic [NUSE_W-1:0] raw);
    logic [SLOT_W-1:0] n;
    if (raw == '0) begin
      n = SLOT_W'(1);
    end else if (raw > NUSE_W'(MAX_BOUNDS)) begin
      n = SLOT_W'(MAX_BOUNDS);
    end else begin
      n = SLOT_W'(raw);
    end
    return n;
  endfunction

  // Product with the full scale, 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4.
  function automatic logic [PROD_W-1:0] times_full_scale(input logic [DATA_W-1:0] v);
    logic [PROD_W-1:0] w;
    w = PROD_W'(v);
    return (w << 13) + (w << 10) + (w << 9) + (w << 8) + (w << 4);
  endfunction

endpackage

`default_nettype wire

[sv/lhp_in_if.sv]
// Request channel of the latency histogram: valid/ready plus the request fields.
// Depends on lhp_pkg for field widths.
`default_nettype none

interface lhp_in_if import lhp_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [DATA_W-1:0] sample;
  logic [PCT_W-1:0]  percent_hundredths;

  modport source (output valid, output req_type, output sample,
                  output percent_hundredths, input ready);
  modport sink   (input valid, input req_type, input sample,
                  input percent_hundredths, output ready);
endinterface

`default_nettype wire

[sv/lhp_out_if.sv]
// Result channel of the latency histogram: valid/ready plus the result fields.
// Depends on lhp_pkg for field widths.
`default_nettype none

interface lhp_out_if import lhp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample_total;
  logic [DATA_W-1:0] smallest_seen;
  logic [DATA_W-1:0] largest_seen;
  logic [DATA_W-1:0] running_sum;
  logic [ANS_W-1:0]  percentile_bound;

  modport source (output valid, output sample_total, output smallest_seen,
                  output largest_seen, output running_sum,
                  output percentile_bound, input ready);
  modport sink   (input valid, input sample_total, input smallest_seen,
                  input largest_seen, input running_sum,
                  input percentile_bound, output ready);
endinterface

`default_nettype wire

[sv/lhp_regs.sv]
// APB-style configuration registers: bound count and four packed bound pairs.
// Depends on lhp_pkg.
`default_nettype none

module lhp_regs import lhp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [NUSE_W-1:0]  n_raw_r;
  logic [BOUND_W-1:0] bound_r [MAX_BOUNDS];
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:REG_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_raw_r <= NUSE_W'(MAX_BOUNDS);
      for (int i = 0; i < MAX_BOUNDS; i++) begin
        bound_r[i] <= '0;
      end
    end else if (wr_en) begin
      case (idx)
        REG_BOUNDS_IN_USE: n_raw_r <= pwdata[NUSE_W-1:0];
        REG_PAIR_0: begin
          bound_r[0] <= pwdata[BOUND_W-1:0];
          bound_r[1] <= pwdata[CFG_DW-1:BOUND_W];
        end
        REG_PAIR_1: begin
          bound_r[2] <= pwdata[BOUND_W-1:0];
          bound_r[3] <= pwdata[CFG_DW-1:BOUND_W];
        end
        REG_PAIR_2: begin
          bound_r[4] <= pwdata[BOUND_W-1:0];
          bound_r[5] <= pwdata[CFG_DW-1:BOUND_W];
        end
        REG_PAIR_3: begin
          bound_r[6] <= pwdata[BOUND_W-1:0];
          bound_r[7] <= pwdata[CFG_DW-1:BOUND_W];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BOUNDS_IN_USE: prdata = CFG_DW'(n_raw_r);
      REG_PAIR_0:        prdata = {bound_r[1], bound_r[0]};
      REG_PAIR_1:        prdata = {bound_r[3], bound_r[2]};
      REG_PAIR_2:        prdata = {bound_r[5], bound_r[4]};
      REG_PAIR_3:        prdata = {bound_r[7], bound_r[6]};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.n_raw = n_raw_r;
    for (int i = 0; i < MAX_BOUNDS; i++) begin
      cfg.bound[i] = bound_r[i];
    end
  end

endmodule

`default_nettype wire

[sv/lhp_ctrl.sv]
// Sequencing state machine of the latency histogram; drives datapath commands.
// Depends on lhp_pkg for the state, command and status types.
`default_nettype none

module lhp_ctrl import lhp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_req_type,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  lhp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_req_type == REQ_RECORD) begin
            state_nxt = ST_REC;
          end else if (stat.count_zero) begin
            // An empty histogram answers zero without any arithmetic.
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_REC: begin
        if (stat.out_free) begin
          cmd.rec_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          state_nxt = ST_TGT;
        end
      end
      ST_TGT: begin
        cmd.tgt_load = 1'b1;
        state_nxt    = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.qry_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/lhp_dp.sv]
// Datapath of the latency histogram: statistics, bucket counters, shift-add
// multiplier, scaled bucket walk and result register.
// Depends on lhp_pkg.
`default_nettype none

module lhp_dp import lhp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire cfg_t              cfg,
  input  wire logic [DATA_W-1:0] in_sample,
  input  wire logic [PCT_W-1:0]  in_pct,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] out_total,
  output logic      [DATA_W-1:0] out_min,
  output logic      [DATA_W-1:0] out_max,
  output logic      [DATA_W-1:0] out_sum,
  output logic      [ANS_W-1:0]  out_bound
);

  // Running statistics and bucket counters.
  logic [DATA_W-1:0] count_r, min_r, max_r, sum_r;
  logic [DATA_W-1:0] cnt_r [BUCKET_SLOTS];

  // Request capture and query arithmetic.
  logic [DATA_W-1:0] sample_r;
  logic [PCT_W-1:0]  pct_r;
  logic [PROD_W-1:0] acc_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W-1:0] cum_r;
  logic [PROD_W-1:0] scl_r;
  logic [SLOT_W-1:0] idx_r;
  logic [ANS_W-1:0]  ans_r;
  logic              out_valid_r;

  logic [SLOT_W-1:0] n_act;
  logic [BIDX_W-1:0] last_bound;
  logic [SLOT_W-1:0] bkt;
  logic [SLOT_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [PROD_W-1:0] rd_scaled;
  logic [DATA_W-1:0] count_nxt, min_nxt, max_nxt, sum_nxt;
  logic [DATA_W:0]   cum_sum;
  logic [DATA_W-1:0] cum_nxt;
  logic [PROD_W:0]   scl_sum;
  logic [PROD_W:0]   scl_wrap;
  logic [PROD_W-1:0] scl_nxt;
  logic              walk_hit, walk_last;
  logic [PCT_W-1:0]  pct_clamped;

  assign n_act      = active_bounds(cfg.n_raw);
  assign last_bound = BIDX_W'(n_act - SLOT_W'(1));

  // First bound in use that lies above the sample; the overflow bucket otherwise.
  always_comb begin
    bkt = n_act;
    for (int i = MAX_BOUNDS - 1; i >= 0; i--) begin
      if (SLOT_W'(i) < n_act && sample_r < DATA_W'(cfg.bound[i])) begin
        bkt = SLOT_W'(i);
      end
    end
  end

  assign rd_addr = cmd.walk_step ? idx_r : bkt;
  assign rd_data = cnt_r[rd_addr];

  assign count_nxt = count_r + DATA_W'(1);
  assign sum_nxt   = sum_r + sample_r;
  assign min_nxt   = (count_r == '0 || sample_r < min_r) ? sample_r : min_r;
  assign max_nxt   = (sample_r > max_r) ? sample_r : max_r;

  // The running total reaches ceil(p * count / 10000) exactly when 10000 times
  // the total reaches p * count, so the walk keeps a scaled copy of the total
  // beside it and compares that with the product.
  assign rd_scaled = times_full_scale(rd_data);
  assign cum_sum   = {1'b0, cum_r} + {1'b0, rd_data};
  assign cum_nxt   = cum_sum[DATA_W-1:0];
  assign scl_sum   = {1'b0, scl_r} + {1'b0, rd_scaled};
  assign scl_wrap  = scl_sum - WRAP_SCALED;
  assign scl_nxt   = cum_sum[DATA_W] ? scl_wrap[PROD_W-1:0] : scl_sum[PROD_W-1:0];
  assign walk_hit  = scl_nxt >= acc_r;
  assign walk_last = idx_r == n_act;

  assign pct_clamped = (in_pct > PCT_W'(FULL_SCALE)) ? PCT_W'(FULL_SCALE) : in_pct;

  always_comb begin
    stat.count_zero = count_r == '0;
    stat.mul_last   = step_r == STEP_W'(PCT_W - 1);
    stat.walk_end   = walk_hit | walk_last;
    stat.out_free   = ~out_valid_r | out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '1;
      max_r   <= '0;
      sum_r   <= '0;
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.rec_commit) begin
      count_r      <= count_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      sum_r        <= sum_nxt;
      cnt_r[bkt]   <= rd_data + DATA_W'(1);
    end
  end

  // The product p * count is built by shift-add, most significant bit first.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      pct_r    <= pct_clamped;
      acc_r    <= '0;
      step_r   <= '0;
      ans_r    <= '0;
    end
    if (cmd.mul_step) begin
      acc_r  <= {acc_r[PROD_W-2:0], 1'b0} +
                (pct_r[PCT_W-1] ? PROD_W'(count_r) : '0);
      pct_r  <= {pct_r[PCT_W-2:0], 1'b0};
      step_r <= stat.mul_last ? '0 : step_r + STEP_W'(1);
    end
    if (cmd.tgt_load) begin
      cum_r <= '0;
      scl_r <= '0;
      idx_r <= '0;
    end
    if (cmd.walk_step) begin
      cum_r <= cum_nxt;
      scl_r <= scl_nxt;
      idx_r <= idx_r + SLOT_W'(1);
      if (walk_hit && !walk_last) begin
        ans_r <= ANS_W'(cfg.bound[idx_r[BIDX_W-1:0]]);
      end else if (walk_hit || walk_last) begin
        ans_r <= {cfg.bound[last_bound], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rec_commit || cmd.qry_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_commit) begin
      out_total <= count_nxt;
      out_min   <= (count_nxt == '0) ? '0 : min_nxt;
      out_max   <= max_nxt;
      out_sum   <= sum_nxt;
      out_bound <= '0;
    end else if (cmd.qry_load) begin
      out_total <= count_r;
      out_min   <= (count_r == '0) ? '0 : min_r;
      out_max   <= max_r;
      out_sum   <= sum_r;
      out_bound <= ans_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[sv/latency_histogram_percentile.sv]
// Bucketed latency histogram with percentile query.
// Requests arrive on in_ch (valid/ready). A record request drops its sample
// into the first bucket whose bound lies above it and updates count, minimum,
// maximum and sum; a query request returns the bucket bound at which the
// cumulative count reaches ceil(p * count / 10000), or twice the last bound in
// use if that is the overflow bucket. Every request gives one result on out_ch
// (valid/ready) that carries the statistics after it. A record, or a query on
// an empty histogram, is captured in idle and loads its result in ST_REC or
// ST_DONE. Any other query runs a shift-add multiply over the 14 bits of p in
// ST_MUL, clears the walk in ST_TGT, walks one to nine buckets in ST_WALK and
// loads its result in ST_DONE. One request is worked on at a time; the next is
// accepted as soon as the result sits in the output register, even if the
// receiver has not yet taken it. When the receiver stalls, the finished result
// holds and the block waits before loading the next one.
// The bound count and bounds are set through the APB port at byte addresses 0,
// 8, 16, 24, 32 while the block is idle; the user must ensure this, the block
// does not enforce it. Synchronous reset clears all counters and statistics,
// sets the bound count to eight and all bounds to zero.
// Depends on lhp_pkg, lhp_in_if, lhp_out_if, lhp_regs, lhp_ctrl and lhp_dp.
`default_nettype none

module latency_histogram_percentile import lhp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lhp_in_if.sink                 in_ch,
  lhp_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  lhp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lhp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  lhp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .in_sample (in_ch.sample),
    .in_pct    (in_ch.percent_hundredths),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_total (out_ch.sample_total),
    .out_min   (out_ch.smallest_seen),
    .out_max   (out_ch.largest_seen),
    .out_sum   (out_ch.running_sum),
    .out_bound (out_ch.percentile_bound)
  );

  assign in_ch.ready = in_ready;

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.rec_commit, cmd.mul_step,
              cmd.tgt_load, cmd.walk_step, cmd.qry_load}))
    else $error("more than one datapath command in a cycle");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.rec_commit || cmd.mul_step ||
                   cmd.tgt_load || cmd.walk_step || cmd.qry_load))
    else $error("request accepted while a previous one is still in work");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rec_commit || cmd.qry_load) |-> stat.out_free)
    else $error("result loaded over one not yet taken");

  a_rec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && in_ch.req_type == REQ_RECORD) |=> !in_ready)
    else $error("record request did not occupy the block");

endmodule

`default_nettype wire
